// ----- sv/assert_macros.svh -----
// Assertion macros for the palette ramp generator RTL, used by prg_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
`define PRG_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define PRG_ASSERT(lbl, clk, rstn, prop)
`define PRG_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ----- sv/prg_pkg.sv -----
// Shared types, constants and helpers for the palette ramp generator.
package prg_pkg;

  localparam int unsigned POS_W            = 6;
  localparam int unsigned COL_W            = 8;
  localparam int unsigned CNT_W            = POS_W + 1;
  localparam int unsigned ORD_W            = 3;
  localparam int unsigned Q_W              = COL_W + 2;
  localparam int unsigned PALETTE_SIZE_DEF = 64;
  localparam int unsigned FIFO_DEPTH_DEF   = 2;

  localparam logic [ORD_W-1:0] ORD_RGB = 3'd0;
  localparam logic [ORD_W-1:0] ORD_RBG = 3'd1;
  localparam logic [ORD_W-1:0] ORD_GRB = 3'd2;
  localparam logic [ORD_W-1:0] ORD_GBR = 3'd3;
  localparam logic [ORD_W-1:0] ORD_BRG = 3'd4;
  localparam logic [ORD_W-1:0] ORD_BGR = 3'd5;

  // Element 0 is red (or first output channel), 1 green, 2 blue.
  typedef logic [0:2][COL_W-1:0] rgb_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic             err;
    rgb_t             key;
    rgb_t             prev;
  } cmd_t;

  function automatic rgb_t reorder(logic [ORD_W-1:0] ord, rgb_t c);
    rgb_t o;
    case (ord)
      ORD_RBG: o = {c[0], c[2], c[1]};
      ORD_GRB: o = {c[1], c[0], c[2]};
      ORD_GBR: o = {c[1], c[2], c[0]};
      ORD_BRG: o = {c[2], c[0], c[1]};
      ORD_BGR: o = {c[2], c[1], c[0]};
      default: o = c;
    endcase
    return o;
  endfunction

endpackage

// ----- sv/palette_ramp_generator_unit.sv -----
// Palette ramp generator: keys in, interpolated palette entries out.
// A key with no ramp passes from the queue to the key state and the output
// register; a ramp key first runs the 8-step divider, then its ramp entries.
// The ramp engine takes one key at a time from the queue, popping only when
// idle; the output register takes one entry per cycle unless out_ready stalls.
// Reset (rst_n low, synchronous): previous key none and black, order RGB.
module palette_ramp_generator_unit #(
  parameter int unsigned PALETTE_SIZE = prg_pkg::PALETTE_SIZE_DEF,
  parameter int unsigned FIFO_DEPTH   = prg_pkg::FIFO_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [prg_pkg::ORD_W-1:0]  cfg_component_order,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [prg_pkg::POS_W-1:0]  in_key_position,
  input  logic [prg_pkg::COL_W-1:0]  in_key_red,
  input  logic [prg_pkg::COL_W-1:0]  in_key_green,
  input  logic [prg_pkg::COL_W-1:0]  in_key_blue,
  input  logic                       in_start_new,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [prg_pkg::POS_W-1:0]  out_entry_position,
  output logic [prg_pkg::COL_W-1:0]  out_first_channel,
  output logic [prg_pkg::COL_W-1:0]  out_second_channel,
  output logic [prg_pkg::COL_W-1:0]  out_third_channel,
  output logic                       out_run_end,
  output logic                       out_order_error
);

  localparam int unsigned CMD_W = $bits(prg_pkg::cmd_t);

  logic [prg_pkg::ORD_W-1:0] order_r;
  logic                      q_push, q_pop, q_full, q_empty;
  prg_pkg::cmd_t             q_wcmd, q_rcmd;
  logic [CMD_W-1:0]          q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= prg_pkg::ORD_RGB;
    end else if (cfg_valid) begin
      order_r <= cfg_component_order;
    end
  end

  prg_front #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key_position (in_key_position),
    .in_key_red      (in_key_red),
    .in_key_green    (in_key_green),
    .in_key_blue     (in_key_blue),
    .in_start_new    (in_start_new),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_wcmd)
  );

  prg_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wcmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_rcmd = prg_pkg::cmd_t'(q_rdata);

  prg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_cmd              (q_rcmd),
    .q_pop              (q_pop),
    .order              (order_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_entry_position (out_entry_position),
    .out_first_channel  (out_first_channel),
    .out_second_channel (out_second_channel),
    .out_third_channel  (out_third_channel),
    .out_run_end        (out_run_end),
    .out_order_error    (out_order_error)
  );

endmodule

// ----- sv/prg_fifo.sv -----
// Small register queue between the key front end and the ramp engine.
module prg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = prg_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/prg_div.sv -----
// Restoring divider, one quotient bit per cycle, for the ramp step size.
module prg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [prg_pkg::COL_W-1:0]  dividend,
  input  logic [prg_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [prg_pkg::COL_W-1:0]  quo,
  output logic [prg_pkg::CNT_W-1:0]  rem
);

  localparam int unsigned STEP_W = $clog2(prg_pkg::COL_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(prg_pkg::COL_W - 1);

  logic                      busy_r, done_r;
  logic [STEP_W-1:0]         step_r;
  logic [prg_pkg::COL_W-1:0] quo_r;
  logic [prg_pkg::CNT_W-1:0] rem_r, div_r;
  logic [prg_pkg::COL_W-1:0] trial, diff;
  logic                      ge;

  assign trial = {rem_r, quo_r[prg_pkg::COL_W-1]};
  assign ge    = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[prg_pkg::COL_W-2:0], ge};
      // partial remainder always stays below the divisor
      rem_r <= ge ? diff[prg_pkg::CNT_W-1:0] : trial[prg_pkg::CNT_W-1:0];
    end
  end

endmodule

// ----- sv/prg_front.sv -----
// Key front end: accepts keys, tracks the previous key, classifies the run.
module prg_front #(
  parameter int unsigned PALETTE_SIZE = prg_pkg::PALETTE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [prg_pkg::POS_W-1:0]  in_key_position,
  input  logic [prg_pkg::COL_W-1:0]  in_key_red,
  input  logic [prg_pkg::COL_W-1:0]  in_key_green,
  input  logic [prg_pkg::COL_W-1:0]  in_key_blue,
  input  logic                       in_start_new,
  input  logic                       q_full,
  output logic                       q_push,
  output prg_pkg::cmd_t              q_cmd
);

  localparam logic [prg_pkg::POS_W-1:0] POS_MAX = prg_pkg::POS_W'(PALETTE_SIZE - 1);

  logic                      prev_none_r;
  logic [prg_pkg::POS_W-1:0] prev_pos_r;
  prg_pkg::rgb_t             prev_col_r;

  logic                      none_eff;
  logic [prg_pkg::POS_W-1:0] pos_sat;
  logic [prg_pkg::CNT_W-1:0] count;
  logic                      err;
  prg_pkg::rgb_t             key_col;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign key_col  = {in_key_red, in_key_green, in_key_blue};

  always_comb begin
    none_eff = in_start_new || prev_none_r;
    pos_sat  = (in_key_position > POS_MAX) ? POS_MAX : in_key_position;
    err      = 1'b0;
    if (none_eff) begin
      count = {1'b0, pos_sat} + 1'b1;
    end else if (pos_sat <= prev_pos_r) begin
      count = prg_pkg::CNT_W'(1);
      err   = 1'b1;
    end else begin
      count = {1'b0, pos_sat} - {1'b0, prev_pos_r};
    end
    q_cmd.pos   = pos_sat;
    q_cmd.start = pos_sat - count[prg_pkg::POS_W-1:0] + 1'b1;
    q_cmd.count = count;
    q_cmd.err   = err;
    q_cmd.key   = key_col;
    q_cmd.prev  = in_start_new ? '0 : prev_col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_none_r <= 1'b1;
      prev_pos_r  <= '0;
      prev_col_r  <= '0;
    end else if (q_push) begin
      prev_none_r <= 1'b0;
      prev_pos_r  <= pos_sat;
      prev_col_r  <= key_col;
    end
  end

endmodule

// ----- sv/prg_back.sv -----
// Ramp engine: divides the step once per ramp key, then emits one entry per cycle while out_ready allows.
`include "assert_macros.svh"
module prg_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  prg_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  input  logic [prg_pkg::ORD_W-1:0]  order,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [prg_pkg::POS_W-1:0]  out_entry_position,
  output logic [prg_pkg::COL_W-1:0]  out_first_channel,
  output logic [prg_pkg::COL_W-1:0]  out_second_channel,
  output logic [prg_pkg::COL_W-1:0]  out_third_channel,
  output logic                       out_run_end,
  output logic                       out_order_error
);

  localparam int unsigned COL_W = prg_pkg::COL_W;
  localparam int unsigned CNT_W = prg_pkg::CNT_W;
  localparam int unsigned POS_W = prg_pkg::POS_W;
  localparam int unsigned Q_W   = prg_pkg::Q_W;
  localparam int unsigned R_W   = CNT_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_RAMP, S_KEY} state_t;

  state_t                  state_r;
  prg_pkg::cmd_t           cmd_r;
  logic [0:2]              neg_r;
  logic signed [Q_W-1:0]   q_r  [3];
  logic signed [Q_W-1:0]   qs_r [3];
  logic [R_W-1:0]          r_r  [3];
  logic [R_W-1:0]          rs_r [3];
  logic [R_W-1:0]          den_r;
  logic [POS_W-1:0]        idx_r;

  logic                    out_valid_r, out_run_end_r, out_err_r;
  logic [POS_W-1:0]        out_pos_r;
  prg_pkg::rgb_t           out_col_r;

  logic [0:2]              neg_in;
  logic [COL_W-1:0]        mag_in [3];
  logic [0:2]              div_done;
  logic [COL_W-1:0]        div_quo [3];
  logic [CNT_W-1:0]        div_rem [3];
  logic                    all_done, can_load, short_run, div_start, last_ramp;
  logic                    out_load;

  logic signed [Q_W-1:0]   qs_init [3];
  logic [R_W-1:0]          rs_init [3];
  logic signed [Q_W-1:0]   q_step  [3];
  logic [R_W-1:0]          r_step  [3];
  prg_pkg::rgb_t           ramp_col;

  assign short_run = q_cmd.err || (q_cmd.count == CNT_W'(1));
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign div_start = q_pop && !short_run;
  assign all_done  = &div_done;
  assign can_load  = !out_valid_r || out_ready;
  assign out_load  = ((state_r == S_RAMP) || (state_r == S_KEY)) && can_load;
  assign last_ramp = ({1'b0, idx_r} == (cmd_r.count - CNT_W'(2)));

  always_comb begin
    logic signed [COL_W:0]   diff;
    logic signed [Q_W-1:0]   qu;
    logic [CNT_W-1:0]        m;
    logic [R_W:0]            rsum;
    logic                    wrap;
    logic signed [Q_W-1:0]   q_adj;
    logic signed [Q_W-1:0]   val;
    for (int k = 0; k < 3; k++) begin
      diff      = $signed({1'b0, q_cmd.key[k]}) - $signed({1'b0, q_cmd.prev[k]});
      neg_in[k] = diff[COL_W];
      mag_in[k] = neg_in[k] ? COL_W'(-diff) : diff[COL_W-1:0];

      // floor division of the signed delta by count
      qu = $signed({{(Q_W-COL_W){1'b0}}, div_quo[k]});
      if (!neg_r[k]) begin
        qs_init[k] = qu;
        m          = div_rem[k];
      end else if (div_rem[k] == '0) begin
        qs_init[k] = -qu;
        m          = '0;
      end else begin
        qs_init[k] = -qu - Q_W'(1);
        m          = cmd_r.count - div_rem[k];
      end
      rs_init[k] = {m, 1'b0};

      rsum      = {1'b0, r_r[k]} + {1'b0, rs_r[k]};
      wrap      = (rsum >= {1'b0, den_r});
      r_step[k] = wrap ? R_W'(rsum - {1'b0, den_r}) : rsum[R_W-1:0];
      q_step[k] = q_r[k] + qs_r[k] + (wrap ? Q_W'(1) : Q_W'(0));

      // truncate toward zero: bump a negative quotient with a remainder
      q_adj       = (q_r[k][Q_W-1] && (r_r[k] != '0)) ? q_r[k] + Q_W'(1) : q_r[k];
      val         = $signed({{(Q_W-COL_W){1'b0}}, cmd_r.prev[k]}) + q_adj;
      ramp_col[k] = val[COL_W-1:0];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    prg_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (mag_in[g]),
      .divisor  (q_cmd.count),
      .done     (div_done[g]),
      .quo      (div_quo[g]),
      .rem      (div_rem[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_cmd;
            neg_r   <= neg_in;
            state_r <= short_run ? S_KEY : S_DIV;
          end
        end
        S_DIV: begin
          if (all_done) begin
            for (int k = 0; k < 3; k++) begin
              qs_r[k] <= qs_init[k];
              rs_r[k] <= rs_init[k];
              q_r[k]  <= '0;
              r_r[k]  <= {1'b0, cmd_r.count};
            end
            den_r   <= {cmd_r.count, 1'b0};
            idx_r   <= '0;
            state_r <= S_RAMP;
          end
        end
        S_RAMP: begin
          if (can_load) begin
            out_pos_r     <= cmd_r.start + idx_r;
            out_col_r     <= prg_pkg::reorder(order, ramp_col);
            out_run_end_r <= 1'b0;
            out_err_r     <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              q_r[k] <= q_step[k];
              r_r[k] <= r_step[k];
            end
            idx_r <= idx_r + 1'b1;
            if (last_ramp) begin
              state_r <= S_KEY;
            end
          end
        end
        S_KEY: begin
          if (can_load) begin
            out_pos_r     <= cmd_r.pos;
            out_col_r     <= prg_pkg::reorder(order, cmd_r.key);
            out_run_end_r <= 1'b1;
            out_err_r     <= cmd_r.err;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_entry_position = out_pos_r;
  assign out_first_channel  = out_col_r[0];
  assign out_second_channel = out_col_r[1];
  assign out_third_channel  = out_col_r[2];
  assign out_run_end        = out_run_end_r;
  assign out_order_error    = out_err_r;

  `PRG_ASSERT(a_div_done_in_div, clk, rst_n, all_done |-> state_r == S_DIV)
  `PRG_ASSERT(a_rem_below_den, clk, rst_n, state_r == S_RAMP |-> (r_r[0] < den_r) && (r_r[1] < den_r) && (r_r[2] < den_r))
  `PRG_ASSERT(a_err_only_on_key, clk, rst_n, out_valid_r && out_err_r |-> out_run_end_r)
  `PRG_ASSERT_RST(a_reset_idle, clk, !rst_n |=> state_r == S_IDLE && !out_valid_r)

endmodule
